>>> hw/rtl/plrc_pkg.sv
`default_nettype none

package plrc_pkg;

   // Table geometry.
   localparam int MAX_POINTS = 64;
   localparam int ADDR_W     = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);

   // Field widths. Rates carry 24 fraction bits; the format passes through
   // the blend unchanged because the weights are integer day distances.
   localparam int DAY_W  = 20;
   localparam int RATE_W = 32;

   // Blend datapath widths.
   localparam int DEN_W  = DAY_W + 1;
   localparam int PROD_W = DAY_W + RATE_W + 1;
   localparam int ACC_W  = PROD_W + 1;
   localparam int NUM_W  = ACC_W + 1;
   localparam int STEP_W = $clog2(RATE_W);

   // Item opcodes.
   localparam logic MODE_PUSH  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [DAY_W-1:0]  day;
      logic [RATE_W-1:0] rate;
   } point_type;

   typedef struct packed {
      logic              start;
      logic [DAY_W-1:0]  x1;
      logic [DAY_W-1:0]  x2;
      logic [RATE_W-1:0] r1;
      logic [RATE_W-1:0] r2;
   } blend_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [RATE_W-1:0] rate;
   } blend_rsp_type;

   typedef enum logic [2:0] {
      BL_IDLE,
      BL_MUL1,
      BL_MUL2,
      BL_SUM,
      BL_MAG,
      BL_NUM,
      BL_DIV,
      BL_FIN
   } blend_state_type;

   typedef enum logic [1:0] {
      TOP_IDLE,
      TOP_SCAN,
      TOP_BLEND,
      TOP_RESP
   } ctrl_state_type;

endpackage

`default_nettype wire

>>> hw/rtl/plrc_if.sv
`default_nettype none

// Request channel: one item is a push or a query.
interface plrc_req_if;
   logic                            valid;
   logic                            ready;
   logic                            mode;
   logic [plrc_pkg::DAY_W-1:0]      day;
   logic signed [plrc_pkg::RATE_W-1:0] rate_in;

   modport source (output valid, output mode, output day, output rate_in, input ready);
   modport sink (input valid, input mode, input day, input rate_in, output ready);
endinterface

// Response channel: one item per request.
interface plrc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [plrc_pkg::RATE_W-1:0] rate_out;
   logic [1:0]                         status;

   modport source (output valid, output rate_out, output status, input ready);
   modport sink (input valid, input rate_out, input status, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/plrc_point_ram.sv
`default_nettype none

module plrc_point_ram (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [plrc_pkg::ADDR_W-1:0]     wr_addr,
   input  plrc_pkg::point_type             wr_point,
   input  logic [plrc_pkg::ADDR_W-1:0]     rd_addr,
   output plrc_pkg::point_type             rd_point
);
   import plrc_pkg::*;

   point_type point_mem [MAX_POINTS];
   point_type rd_point_ff;

   // Single write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         point_mem[wr_addr] <= wr_point;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_point_ff <= point_mem[rd_addr];
   end

   assign rd_point = rd_point_ff;

endmodule

`default_nettype wire

>>> hw/rtl/plrc_blend.sv
`default_nettype none

module plrc_blend (
   input  logic                    clock,
   input  logic                    reset,
   input  plrc_pkg::blend_req_type blend_req,
   output plrc_pkg::blend_rsp_type blend_rsp
);
   import plrc_pkg::*;

   blend_state_type state_ff, state_in;

   logic [DAY_W-1:0]         x1_ff;
   logic [DAY_W-1:0]         x2_ff;
   logic signed [RATE_W-1:0] r1_ff;
   logic signed [RATE_W-1:0] r2_ff;
   logic [DEN_W-1:0]         den_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic                     neg_ff;
   logic [DEN_W-1:0]         rem_ff;
   logic [RATE_W-1:0]        quo_ff;
   logic [STEP_W-1:0]        step_ff;

   logic [DAY_W-1:0]         mul_x;
   logic signed [RATE_W-1:0] mul_r;
   logic signed [PROD_W-1:0] mul_p;
   logic [NUM_W-1:0]         num;
   logic [DEN_W:0]           shifted;
   logic [DEN_W:0]           diff;
   logic                     fits;

   // One shared multiplier: x2*r1 first, then x1*r2.
   always_comb begin
      mul_x = (state_ff == BL_MUL1) ? x2_ff : x1_ff;
      mul_r = (state_ff == BL_MUL1) ? r1_ff : r2_ff;
      mul_p = $signed({1'b0, mul_x}) * mul_r;
   end

   // Rounding bias: add half the divisor to the magnitude.
   assign num = NUM_W'($unsigned(acc_ff)) + NUM_W'(den_ff >> 1);

   // One restoring division step per cycle.
   assign shifted = {rem_ff, quo_ff[RATE_W-1]};
   assign fits    = shifted >= {1'b0, den_ff};
   assign diff    = shifted - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BL_IDLE: begin
            if (blend_req.start) begin
               state_in = BL_MUL1;
            end
         end
         BL_MUL1: state_in = BL_MUL2;
         BL_MUL2: state_in = BL_SUM;
         BL_SUM:  state_in = BL_MAG;
         BL_MAG:  state_in = BL_NUM;
         BL_NUM:  state_in = BL_DIV;
         BL_DIV: begin
            if (step_ff == STEP_W'(RATE_W - 1)) begin
               state_in = BL_FIN;
            end
         end
         BL_FIN:  state_in = BL_IDLE;
      endcase
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         BL_IDLE: begin
            if (blend_req.start) begin
               x1_ff  <= blend_req.x1;
               x2_ff  <= blend_req.x2;
               r1_ff  <= $signed(blend_req.r1);
               r2_ff  <= $signed(blend_req.r2);
               den_ff <= DEN_W'(blend_req.x1) + DEN_W'(blend_req.x2);
            end
         end
         BL_MUL1: begin
            prod_ff <= mul_p;
         end
         BL_MUL2: begin
            acc_ff  <= ACC_W'(prod_ff);
            prod_ff <= mul_p;
         end
         BL_SUM: begin
            acc_ff <= acc_ff + ACC_W'(prod_ff);
         end
         BL_MAG: begin
            neg_ff <= acc_ff[ACC_W-1];
            if (acc_ff[ACC_W-1]) begin
               acc_ff <= -acc_ff;
            end
         end
         BL_NUM: begin
            // The quotient fits in RATE_W bits, so the upper part is below den.
            rem_ff  <= DEN_W'(num[NUM_W-1:RATE_W]);
            quo_ff  <= num[RATE_W-1:0];
            step_ff <= '0;
         end
         BL_DIV: begin
            rem_ff  <= fits ? DEN_W'(diff) : DEN_W'(shifted);
            quo_ff  <= {quo_ff[RATE_W-2:0], fits};
            step_ff <= step_ff + STEP_W'(1);
         end
         BL_FIN: begin
         end
      endcase
   end

   assign blend_rsp.busy = state_ff != BL_IDLE;
   assign blend_rsp.done = state_ff == BL_FIN;
   assign blend_rsp.rate = neg_ff ? (RATE_W'(0) - quo_ff) : quo_ff;

   // The partial remainder stays below the divisor during the division.
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BL_DIV) |-> (rem_ff < den_ff))
      else $error("partial remainder not below divisor");

endmodule

`default_nettype wire

>>> hw/rtl/piecewise_linear_rate_curve_top.sv
`default_nettype none

// Channel   Direction  Handshake     Payload
// req_ch    in         valid/ready   mode, day, rate_in
// rsp_ch    out        valid/ready   rate_out, status
//
// A push reaches the output register through TOP_RESP once that register is free. A
// query either stops on a stored point without blending or blends two neighbours:
// the scan reads one table entry a cycle, the blend unit computes the weighted mean
// with its bit-serial divider, and TOP_RESP hands the result over.
// Reset is synchronous and empties the table; the memory itself is not cleared.
// The next item is accepted while a result still waits in the output register.
module piecewise_linear_rate_curve_top (
   input logic        clock,
   input logic        reset,
   plrc_req_if.sink   req_ch,
   plrc_rsp_if.source rsp_ch
);
   import plrc_pkg::*;

   ctrl_state_type    state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [DAY_W-1:0]  qday_ff, qday_in;
   point_type         prev_ff, prev_in;
   logic [RATE_W-1:0] fin_rate_ff, fin_rate_in;
   status_type        fin_status_ff, fin_status_in;
   logic              out_valid_ff, out_valid_in;
   logic [RATE_W-1:0] out_rate_ff, out_rate_in;
   status_type        out_status_ff, out_status_in;

   blend_req_type     blend_req;
   blend_rsp_type     blend_rsp;
   logic              wr_en;
   point_type         wr_point;
   logic [ADDR_W-1:0] rd_addr;
   point_type         rd_point;
   logic              req_fire;
   logic              out_free;
   logic              scan_last;

   plrc_point_ram u_point_ram (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (count_ff[ADDR_W-1:0]),
      .wr_point (wr_point),
      .rd_addr  (rd_addr),
      .rd_point (rd_point)
   );

   plrc_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .blend_req (blend_req),
      .blend_rsp (blend_rsp)
   );

   // Handshake status.
   assign req_ch.ready = state_ff == TOP_IDLE;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign scan_last    = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;

   // Control: push, table scan, blend and response hand-off.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      qday_in       = qday_ff;
      prev_in       = prev_ff;
      fin_rate_in   = fin_rate_ff;
      fin_status_in = fin_status_ff;
      out_valid_in  = out_valid_ff && !rsp_ch.ready;
      out_rate_in   = out_rate_ff;
      out_status_in = out_status_ff;
      wr_en         = 1'b0;
      wr_point.day  = req_ch.day;
      wr_point.rate = req_ch.rate_in;
      rd_addr       = '0;
      blend_req     = '0;
      blend_req.x1  = qday_ff - prev_ff.day;
      blend_req.x2  = rd_point.day - qday_ff;
      blend_req.r1  = prev_ff.rate;
      blend_req.r2  = rd_point.rate;

      unique case (state_ff)
         TOP_IDLE: begin
            if (req_fire) begin
               qday_in = req_ch.day;
               idx_in  = '0;
               if (req_ch.mode == MODE_PUSH) begin
                  fin_rate_in = '0;
                  if (count_ff < CNT_W'(MAX_POINTS)) begin
                     wr_en         = 1'b1;
                     count_in      = count_ff + CNT_W'(1);
                     fin_status_in = ST_OK;
                  end else begin
                     fin_status_in = ST_FULL;
                  end
                  state_in = TOP_RESP;
               end else if (count_ff == '0) begin
                  fin_rate_in   = '0;
                  fin_status_in = ST_RANGE;
                  state_in      = TOP_RESP;
               end else begin
                  state_in = TOP_SCAN;
               end
            end
         end
         TOP_SCAN: begin
            // Prefetch the next entry while the current one is compared.
            rd_addr = idx_ff + ADDR_W'(1);
            if (qday_ff > rd_point.day) begin
               if (scan_last) begin
                  fin_rate_in   = '0;
                  fin_status_in = ST_RANGE;
                  state_in      = TOP_RESP;
               end else begin
                  prev_in = rd_point;
                  idx_in  = idx_ff + ADDR_W'(1);
               end
            end else if (idx_ff == '0) begin
               // Exact hit on the first point, or a day before it.
               if (qday_ff == rd_point.day) begin
                  fin_rate_in   = rd_point.rate;
                  fin_status_in = ST_OK;
               end else begin
                  fin_rate_in   = '0;
                  fin_status_in = ST_RANGE;
               end
               state_in = TOP_RESP;
            end else begin
               blend_req.start = 1'b1;
               state_in        = TOP_BLEND;
            end
         end
         TOP_BLEND: begin
            if (blend_rsp.done) begin
               fin_rate_in   = blend_rsp.rate;
               fin_status_in = ST_OK;
               state_in      = TOP_RESP;
            end
         end
         TOP_RESP: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_rate_in   = fin_rate_ff;
               out_status_in = fin_status_ff;
               state_in      = TOP_IDLE;
            end
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TOP_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      qday_ff       <= qday_in;
      prev_ff       <= prev_in;
      fin_rate_ff   <= fin_rate_in;
      fin_status_ff <= fin_status_in;
      out_rate_ff   <= out_rate_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.rate_out = out_rate_ff;
   assign rsp_ch.status   = out_status_ff;

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("point count above table size");

   a_scan_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == TOP_SCAN) |-> (CNT_W'(idx_ff) < count_ff))
      else $error("scan index beyond stored points");

   a_blend_start_idle: assert property (@(posedge clock) disable iff (reset)
      blend_req.start |-> !blend_rsp.busy)
      else $error("blend started while busy");

endmodule

`default_nettype wire

>>> tb/testbench.sv
`default_nettype none

module testbench;
   import plrc_pkg::*;

   localparam int unsigned DAY_MAX = (1 << DAY_W) - 1;

   // One expected response item.
   typedef struct packed {
      logic signed [RATE_W-1:0] rate;
      status_type               status;
   } curve_result_type;

   // Keeps its own copy of the point table and predicts one response per request.
   class rate_curve_scoreboard;
      logic [DAY_W-1:0]         point_day [MAX_POINTS];
      logic signed [RATE_W-1:0] point_rate [MAX_POINTS];
      int unsigned              point_total;
      curve_result_type         expected_q [$];
      int                       errors;
      int                       checked;
      int                       n_push;
      int                       n_full;
      int                       n_query;
      int                       n_blend;
      int                       n_range;

      function new();
         point_total = 0;
         errors      = 0;
         checked     = 0;
         n_push      = 0;
         n_full      = 0;
         n_query     = 0;
         n_blend     = 0;
         n_range     = 0;
      endfunction

      // Weighted mean of two rates, rounded to nearest with ties away from zero.
      function logic signed [RATE_W-1:0] weighted_rate(logic [DAY_W-1:0] x1,
                                                       logic [DAY_W-1:0] x2,
                                                       logic signed [RATE_W-1:0] r1,
                                                       logic signed [RATE_W-1:0] r2);
         longint          num;
         longint unsigned den;
         longint unsigned mag;
         longint unsigned quo;
         longint unsigned res;
         logic            neg;
         num = longint'(x2) * longint'(r1) + longint'(x1) * longint'(r2);
         den = x1 + x2;
         neg = (num < 0);
         mag = neg ? -num : num;
         quo = (mag + den / 2) / den;
         res = neg ? -quo : quo;
         return res[RATE_W-1:0];
      endfunction

      // Called when a request item is accepted by the block.
      function void note_request(logic mode, logic [DAY_W-1:0] day,
                                 logic signed [RATE_W-1:0] rate);
         curve_result_type res;
         int unsigned      i;
         res.rate   = '0;
         res.status = ST_OK;
         if (mode == MODE_PUSH) begin
            n_push++;
            if (point_total < MAX_POINTS) begin
               point_day[point_total]  = day;
               point_rate[point_total] = rate;
               point_total++;
            end else begin
               res.status = ST_FULL;
               n_full++;
            end
         end else begin
            n_query++;
            if (point_total == 0 || day < point_day[0]) begin
               res.status = ST_RANGE;
            end else if (day == point_day[0]) begin
               res.rate = point_rate[0];
            end else begin
               // First point whose day is not below the query day.
               i = 1;
               while (i < point_total && day > point_day[i]) i++;
               if (i >= point_total) begin
                  res.status = ST_RANGE;
               end else begin
                  res.rate = weighted_rate(day - point_day[i-1], point_day[i] - day,
                                           point_rate[i-1], point_rate[i]);
                  n_blend++;
               end
            end
            if (res.status == ST_RANGE) n_range++;
         end
         expected_q.insert(expected_q.size(), res);
      endfunction

      // Called when a response item is accepted from the block.
      function void check_response(logic signed [RATE_W-1:0] rate, logic [1:0] status);
         curve_result_type want;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: response with nothing expected: rate_out=%h status=%0d",
                        rate, status);
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (want.rate !== rate || want.status !== status) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: item %0d: expected rate_out=%h status=%0d, got %h status=%0d",
                        checked, want.rate, want.status, rate, status);
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   plrc_req_if req_ch ();
   plrc_rsp_if rsp_ch ();

   piecewise_linear_rate_curve_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   rate_curve_scoreboard sb = new();

   // Days of the points the table should hold, kept for building queries.
   int unsigned stored_days [$];
   bit          no_idle;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(60, 10);
   endfunction

   // Offers one request item, after an optional idle gap, and waits for acceptance.
   task automatic send_item(input logic mode, input logic [DAY_W-1:0] day,
                            input logic [RATE_W-1:0] rate);
      int gap;
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.mode    <= mode;
      req_ch.day     <= day;
      req_ch.rate_in <= rate;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(mode, day, rate);
      if (mode == MODE_PUSH && stored_days.size() < MAX_POINTS)
         stored_days.insert(stored_days.size(), day);
   endtask

   // Response side: random stalls, one long hold-off, and a stretch with none.
   initial begin : response_side
      int stall_left;
      bit hold_done;
      stall_left   = 0;
      hold_done    = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) sb.check_response(rsp_ch.rate_out, rsp_ch.status);
         if (!hold_done && sb.checked >= 120) begin
            hold_done  = 1'b1;
            stall_left = 600;
         end else if (stall_left == 0 && !(sb.checked >= 350 && sb.checked < 430)) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Request side: directed items, then random pushes and queries.
   initial begin : request_side
      int unsigned         chain_day;
      int unsigned         next_day;
      int unsigned         pick;
      int unsigned         idx;
      logic [DAY_W-1:0]    day;
      logic [RATE_W-1:0]   rate;
      reset          = 1'b1;
      no_idle        = 1'b0;
      req_ch.valid   = 1'b0;
      req_ch.mode    = MODE_PUSH;
      req_ch.day     = '0;
      req_ch.rate_in = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Empty table, single point, rate extremes, tie rounding, exact hits,
      // duplicate days, day extremes and an out-of-order point.
      send_item(MODE_QUERY, 20'd5,     32'h1234_5678);
      send_item(MODE_PUSH,  20'd100,   32'h7FFF_FFFF);
      send_item(MODE_QUERY, 20'd99,    32'h0);
      send_item(MODE_QUERY, 20'd100,   32'hFFFF_FFFF);
      send_item(MODE_QUERY, 20'd101,   32'h0);
      send_item(MODE_PUSH,  20'd200,   32'h8000_0000);
      send_item(MODE_QUERY, 20'd150,   32'h0);
      send_item(MODE_QUERY, 20'd200,   32'h0);
      send_item(MODE_QUERY, 20'd201,   32'h0);
      send_item(MODE_QUERY, 20'd101,   32'h0);
      send_item(MODE_QUERY, 20'd199,   32'h0);
      send_item(MODE_PUSH,  20'd300,   32'hFFFF_FFFF);
      send_item(MODE_PUSH,  20'd300,   32'h0100_0000);
      send_item(MODE_QUERY, 20'd300,   32'h0);
      send_item(MODE_QUERY, 20'd250,   32'h0);
      send_item(MODE_QUERY, 20'd0,     32'h0);
      send_item(MODE_QUERY, 20'hFFFFF, 32'h0);
      send_item(MODE_PUSH,  20'd290,   32'h0000_0000);
      send_item(MODE_QUERY, 20'd295,   32'h0);
      send_item(MODE_QUERY, 20'd305,   32'h0);

      // Random part: the table grows in ascending order until it is full,
      // with some duplicate and out-of-order points mixed in.
      chain_day = 300;
      for (int n = 0; n < 500; n++) begin
         no_idle = (n >= 200 && n < 280);
         if (n == 320) begin
            req_ch.valid <= 1'b0;
            do @(posedge clock); while (sb.pending() != 0);
         end
         if ($urandom_range(99) < 15) begin
            if ($urandom_range(99) < 15) begin
               case ($urandom_range(3))
                  0:       rate = 32'h7FFF_FFFF;
                  1:       rate = 32'h8000_0000;
                  2:       rate = 32'h0;
                  default: rate = 32'hFFFF_FFFF;
               endcase
            end else begin
               rate = $urandom;
            end
            pick = $urandom_range(9);
            if (pick == 0) begin
               day = DAY_W'($urandom);
            end else begin
               if (pick != 1) begin
                  next_day  = chain_day + $urandom_range(32000, 1);
                  chain_day = (next_day > DAY_MAX) ? DAY_MAX : next_day;
               end
               day = DAY_W'(chain_day);
            end
            send_item(MODE_PUSH, day, rate);
         end else begin
            pick = $urandom_range(99);
            idx  = $urandom_range(stored_days.size() - 1);
            if (pick < 5) begin
               day = DAY_W'($urandom);
            end else if (pick < 50) begin
               day = DAY_W'($urandom_range(chain_day, stored_days[0]));
            end else if (pick < 70) begin
               day = DAY_W'(stored_days[idx]);
            end else if (pick < 80) begin
               day = $urandom_range(1) ? DAY_W'(stored_days[idx] + 1)
                                       : DAY_W'(stored_days[idx] - 1);
            end else if (pick < 90) begin
               day = (stored_days[0] == 0) ? '0
                                           : DAY_W'($urandom_range(stored_days[0] - 1, 0));
            end else begin
               day = (chain_day >= DAY_MAX) ? DAY_W'(DAY_MAX)
                                            : DAY_W'($urandom_range(DAY_MAX, chain_day + 1));
            end
            send_item(MODE_QUERY, day, $urandom);
         end
      end
      req_ch.valid <= 1'b0;

      // Drain, then watch for stray responses.
      do @(posedge clock); while (sb.pending() != 0);
      repeat (150) @(posedge clock);

      $display("Run covered %0d pushes (%0d into a full table) and %0d queries",
               sb.n_push, sb.n_full, sb.n_query);
      $display("(%0d interpolated, %0d out of range); %0d responses checked, %0d points held.",
               sb.n_blend, sb.n_range, sb.checked, sb.point_total);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("%0d mismatches in total.", sb.errors);
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog.
   initial begin : watchdog
      #(12 * 600000);
      $display("Timeout with %0d responses still expected.", sb.pending());
      $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire

>>> sim.f
hw/rtl/plrc_pkg.sv
hw/rtl/plrc_if.sv
hw/rtl/plrc_point_ram.sv
hw/rtl/plrc_blend.sv
hw/rtl/piecewise_linear_rate_curve_top.sv
tb/testbench.sv
